### src/crp_pkg.sv
// Shared types, constants and helpers for the cell reference parser.
`timescale 1ns / 1ps
`default_nettype none

package crp_pkg;

    // Parse position within one reference
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_COLDOL  = 3'd1,
        PH_LETTERS = 3'd2,
        PH_ROWDOL  = 3'd3,
        PH_DIGITS  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_MALFORMED = 3'd1,
        ERR_COL_HIGH  = 3'd2,
        ERR_ROW_HIGH  = 3'd3,
        ERR_ROW_ZERO  = 3'd4
    } t_err;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned COL_W     = 15;
    localparam int unsigned COL_ACC_W = 16;
    localparam int unsigned ROW_W     = 21;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;

    localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;

    localparam logic [COL_ACC_W-1:0] COL_SAT = '1;
    localparam logic [ROW_W-1:0]     ROW_SAT = '1;

    localparam logic [COL_W-1:0] MAX_COL_RST = 15'd32767;
    localparam logic [ROW_W-1:0] MAX_ROW_RST = 21'd65536;

    // Register index, taken from paddr[2]
    localparam logic REG_MAX_COL = 1'b0;
    localparam logic REG_MAX_ROW = 1'b1;

    // Letter value 1..26 for A-Z or a-z, else 0
    function automatic logic [4:0] letter_value(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] d;
        begin
            d = '0;
            if (ch inside {[8'h41:8'h5A]}) begin
                d = ch - CH_UPPER_A + 8'd1;
            end else if (ch inside {[8'h61:8'h7A]}) begin
                d = ch - CH_LOWER_A + 8'd1;
            end
            return d[4:0];
        end
    endfunction

    function automatic logic is_digit(input logic [CH_W-1:0] ch);
        return ch inside {[8'h30:8'h39]};
    endfunction

endpackage

`default_nettype wire

### src/cell_reference_parser.sv
// Top level of the A1-style cell reference parser.
`timescale 1ns / 1ps
`default_nettype none

// Parses one A1-style cell reference ("Sheet1!$B$12", "aa7", ...) fed one
// byte per item, with i_last marking the final byte. Everything up to the
// first '!' is treated as a sheet name, dropped, and flagged in
// o_sheet_given. The result item comes out of a register in the cycle after
// the last byte is taken and carries an error code (first error sticks,
// row checks made last), the column (A = 1), the row and the '$' flags;
// column and row read zero on error. The block takes one byte every
// cycle unless stalled: each byte is one pass through the parse logic
// into the state registers. Non-final bytes are taken even while a result
// sits stalled in the output register; a final byte waits only while that
// single result register is full and stalled downstream. The user must
// write max_column and max_row over APB only while no reference is in
// flight (not enforced here); both read back at addresses 0 and 4.
module cell_reference_parser
    import crp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    // APB configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,

    // byte input
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CH_W-1:0]   i_ch,
    input  wire logic              i_last,

    // result output
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_error_code,
    output logic [COL_W-1:0]       o_column,
    output logic [ROW_W-1:0]       o_row,
    output logic                   o_column_fixed,
    output logic                   o_row_fixed,
    output logic                   o_sheet_given
);

    // configuration
    logic [COL_W-1:0] r_max_col;
    logic [ROW_W-1:0] r_max_row;
    logic             cfg_wr;

    // parse state
    t_phase                 r_phase,      n_phase;
    logic [COL_ACC_W-1:0]   r_col_acc,    n_col_acc;
    logic [ROW_W-1:0]       r_row_acc,    n_row_acc;
    logic                   r_col_dollar, n_col_dollar;
    logic                   r_row_dollar, n_row_dollar;
    logic                   r_sheet_seen, n_sheet_seen;
    t_err                   r_err,        n_err;

    // result register
    logic                   r_out_valid;
    t_err                   r_res_err,    n_res_err;
    logic [COL_W-1:0]       r_res_col,    n_res_col;
    logic [ROW_W-1:0]       r_res_row,    n_res_row;
    logic                   r_res_cfix;
    logic                   r_res_rfix;
    logic                   r_res_sheet;

    logic                   in_acc;
    logic                   bang;
    logic [4:0]             lv;
    logic                   dig;
    logic [ROW_W-1:0]       col_prod;
    logic [ROW_W+3:0]       row_prod;
    logic [COL_ACC_W-1:0]   col_add;
    logic [ROW_W-1:0]       row_add;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        if (paddr[2] == REG_MAX_ROW) begin
            prdata = {{(DATA_W-ROW_W){1'b0}}, r_max_row};
        end else begin
            prdata = {{(DATA_W-COL_W){1'b0}}, r_max_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_col <= MAX_COL_RST;
            r_max_row <= MAX_ROW_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MAX_COL) begin
                r_max_col <= pwdata[COL_W-1:0];
            end else begin
                r_max_row <= pwdata[ROW_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------- handshake
    // Only a final byte needs room in the result register.
    assign o_in_stall = r_out_valid & i_out_stall & i_last;
    assign in_acc     = i_in_valid & ~o_in_stall;

    // ---------------------------------------------------- accumulate step
    assign lv   = letter_value(i_ch);
    assign dig  = is_digit(i_ch);
    assign bang = (i_ch == CH_BANG) && !r_sheet_seen;

    // column * 26 + letter, saturating at the 16-bit limit
    assign col_prod = {{(ROW_W-COL_ACC_W){1'b0}}, r_col_acc} * ROW_W'(26)
                    + {{(ROW_W-5){1'b0}}, lv};
    assign col_add  = (col_prod > {{(ROW_W-COL_ACC_W){1'b0}}, COL_SAT}) ?
                      COL_SAT : col_prod[COL_ACC_W-1:0];

    // row * 10 + digit, saturating at the 21-bit limit
    assign row_prod = {4'b0, r_row_acc} * (ROW_W+4)'(10)
                    + {{ROW_W{1'b0}}, (i_ch[3:0] - CH_ZERO[3:0])};
    assign row_add  = (row_prod > {4'b0, ROW_SAT}) ? ROW_SAT : row_prod[ROW_W-1:0];

    // ------------------------------------------------- next parse state
    always_comb begin
        n_phase      = r_phase;
        n_col_acc    = r_col_acc;
        n_row_acc    = r_row_acc;
        n_col_dollar = r_col_dollar;
        n_row_dollar = r_row_dollar;
        n_sheet_seen = r_sheet_seen;
        n_err        = r_err;

        if (bang) begin
            // sheet prefix ends: restart the parse
            n_phase      = PH_START;
            n_col_acc    = '0;
            n_row_acc    = '0;
            n_col_dollar = 1'b0;
            n_row_dollar = 1'b0;
            n_err        = ERR_OK;
            n_sheet_seen = 1'b1;
        end else if (r_err == ERR_OK) begin
            case (r_phase)
                PH_START: begin
                    if (i_ch == CH_DOLLAR) begin
                        n_col_dollar = 1'b1;
                        n_phase      = PH_COLDOL;
                    end else if (lv != 5'd0) begin
                        n_col_acc = col_add;
                        n_phase   = PH_LETTERS;
                    end else begin
                        n_err = ERR_MALFORMED;
                    end
                end
                PH_COLDOL: begin
                    if (lv != 5'd0) begin
                        n_col_acc = col_add;
                        n_phase   = PH_LETTERS;
                    end else begin
                        n_err = ERR_MALFORMED;
                    end
                end
                PH_LETTERS: begin
                    if (lv != 5'd0) begin
                        n_col_acc = col_add;
                    end else if (r_col_acc > {1'b0, r_max_col}) begin
                        // too-high column beats a bad byte here
                        n_err = ERR_COL_HIGH;
                    end else if (i_ch == CH_DOLLAR) begin
                        n_row_dollar = 1'b1;
                        n_phase      = PH_ROWDOL;
                    end else if (dig) begin
                        n_row_acc = row_add;
                        n_phase   = PH_DIGITS;
                    end else begin
                        n_err = ERR_MALFORMED;
                    end
                end
                PH_ROWDOL: begin
                    if (dig) begin
                        n_row_acc = row_add;
                        n_phase   = PH_DIGITS;
                    end else begin
                        n_err = ERR_MALFORMED;
                    end
                end
                PH_DIGITS: begin
                    if (dig) begin
                        n_row_acc = row_add;
                    end else begin
                        n_err = ERR_MALFORMED;
                    end
                end
                default: begin
                    n_err = ERR_MALFORMED;
                end
            endcase
        end
    end

    // ----------------------------------------------------- result fields
    always_comb begin
        n_res_err = n_err;
        if (n_err == ERR_OK) begin
            if (n_phase != PH_DIGITS) begin
                n_res_err = ERR_MALFORMED;   // ended before any row digit
            end else if (n_row_acc == ROW_SAT || n_row_acc > r_max_row) begin
                n_res_err = ERR_ROW_HIGH;
            end else if (n_row_acc == '0) begin
                n_res_err = ERR_ROW_ZERO;
            end
        end
        if (n_res_err == ERR_OK) begin
            n_res_col = n_col_acc[COL_W-1:0];
            n_res_row = n_row_acc;
        end else begin
            n_res_col = '0;
            n_res_row = '0;
        end
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_col_acc    <= '0;
            r_row_acc    <= '0;
            r_col_dollar <= 1'b0;
            r_row_dollar <= 1'b0;
            r_sheet_seen <= 1'b0;
            r_err        <= ERR_OK;
        end else if (in_acc) begin
            if (i_last) begin
                // reference done: back to a clean start
                r_phase      <= PH_START;
                r_col_acc    <= '0;
                r_row_acc    <= '0;
                r_col_dollar <= 1'b0;
                r_row_dollar <= 1'b0;
                r_sheet_seen <= 1'b0;
                r_err        <= ERR_OK;
            end else begin
                r_phase      <= n_phase;
                r_col_acc    <= n_col_acc;
                r_row_acc    <= n_row_acc;
                r_col_dollar <= n_col_dollar;
                r_row_dollar <= n_row_dollar;
                r_sheet_seen <= n_sheet_seen;
                r_err        <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last) begin
            r_res_err   <= n_res_err;
            r_res_col   <= n_res_col;
            r_res_row   <= n_res_row;
            r_res_cfix  <= n_col_dollar;
            r_res_rfix  <= n_row_dollar;
            r_res_sheet <= n_sheet_seen;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_error_code   = r_res_err;
    assign o_column       = r_res_col;
    assign o_row          = r_res_row;
    assign o_column_fixed = r_res_cfix;
    assign o_row_fixed    = r_res_rfix;
    assign o_sheet_given  = r_res_sheet;

    // --------------------------------------------------------- assertions
    a_err_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != ERR_OK) |-> (o_column == '0 && o_row == '0))
        else $error("error result carries nonzero column or row");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> o_out_valid)
        else $error("final byte taken but no result presented");

    a_row_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DIGITS) |-> (r_row_acc == '0))
        else $error("row accumulator busy outside digit phase");

    a_ok_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code == ERR_OK && $stable(r_max_row))
            |-> (o_row != '0 && o_row <= r_max_row))
        else $error("accepted row outside limits");

endmodule

`default_nettype wire
